/* hdl/cbe_pkg.sv */
// Shared types and constants for the color blend equation block.
// No dependencies.
package cbe_pkg;

  localparam int unsigned LANES = 4;
  localparam int unsigned CH_W  = 8;
  localparam int unsigned PROD_W = 2 * CH_W;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned MODE_W = 3;

  localparam logic [MODE_W-1:0] MODE_ADD  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SUB  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RSUB = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MIN  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MAX  = 3'd4;

  // 255 * 255: any value at or above this divides to the channel maximum
  localparam logic [SUM_W-1:0] CLAMP_LIMIT = 17'd65025;
  localparam logic [CH_W-1:0]  CH_MAX      = 8'd255;

  typedef logic [CH_W-1:0]   chan_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [MODE_W-1:0] mode_t;

endpackage

/* hdl/color_blend_equation.sv */
// Color blend equation: top level, three-stage pipelined blender.
// Depends on cbe_pkg.
//
// Usage:
//   s_tdata carries one pixel request: source_color [31:0], source_factor
//   [63:32], dest_color [95:64], dest_factor [127:96], each rgba with r in the
//   low byte. m_tdata returns red_out [7:0], green_out [15:8], blue_out
//   [23:16], alpha_out [31:24].
//   blend_mode is written through blend_mode_we / blend_mode_wdata while no
//   request is in flight: 0 add, 1 subtract, 2 reverse subtract, 3 min, 4 max.
//   Codes 5 to 7 give all-zero results.
// Pipeline: multiply, combine, divide by 255 with clamp, one register each.
// Throughput: one request per cycle unless stalled; the three stages advance together.
// Stall: when m_tvalid is high and m_tready low the whole pipeline holds and
//   s_tready drops; s_tready is high whenever the output register is empty
//   or being taken.
// Reset: rst clears all stage valid bits and sets blend_mode to add.
module color_blend_equation (
  input  logic         clk,
  input  logic         rst,
  input  logic         blend_mode_we,
  input  logic [2:0]   blend_mode_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // source_color, source_factor, dest_color, dest_factor
  input  logic [127:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // red_out, green_out, blue_out, alpha_out
  output logic [31:0]  m_tdata
);

  localparam int unsigned L = cbe_pkg::LANES;
  localparam int unsigned W = cbe_pkg::CH_W;

  cbe_pkg::mode_t blend_mode;

  logic           v1, v2, v3;
  cbe_pkg::prod_t p1 [L];
  cbe_pkg::prod_t q1 [L];
  cbe_pkg::sum_t  r2 [L];
  cbe_pkg::chan_t o3 [L];

  cbe_pkg::prod_t p_next [L];
  cbe_pkg::prod_t q_next [L];
  cbe_pkg::sum_t  r_next [L];
  cbe_pkg::chan_t o_next [L];

  logic adv;

  assign adv      = !v3 || m_tready;
  assign s_tready = adv;
  assign m_tvalid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode <= cbe_pkg::MODE_ADD;
    end else if (blend_mode_we) begin
      blend_mode <= blend_mode_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // stage 1: per-lane products
  always_comb begin
    for (int i = 0; i < L; i++) begin
      p_next[i] = s_tdata[i*W +: W] * s_tdata[32 + i*W +: W];
      q_next[i] = s_tdata[64 + i*W +: W] * s_tdata[96 + i*W +: W];
    end
  end

  // stage 2: equation, negative results forced to zero
  always_comb begin
    for (int i = 0; i < L; i++) begin
      unique case (blend_mode)
        cbe_pkg::MODE_ADD:  r_next[i] = {1'b0, p1[i]} + {1'b0, q1[i]};
        cbe_pkg::MODE_SUB:  r_next[i] = (p1[i] >= q1[i]) ? {1'b0, p1[i] - q1[i]} : '0;
        cbe_pkg::MODE_RSUB: r_next[i] = (q1[i] >= p1[i]) ? {1'b0, q1[i] - p1[i]} : '0;
        cbe_pkg::MODE_MIN:  r_next[i] = (p1[i] < q1[i]) ? {1'b0, p1[i]} : {1'b0, q1[i]};
        cbe_pkg::MODE_MAX:  r_next[i] = (p1[i] > q1[i]) ? {1'b0, p1[i]} : {1'b0, q1[i]};
        default:            r_next[i] = '0;
      endcase
    end
  end

  // stage 3: x / 255 = (x + 1 + (x >> 8)) >> 8 for x below 255*255
  always_comb begin
    logic [cbe_pkg::SUM_W-1:0] t;
    for (int i = 0; i < L; i++) begin
      t = r2[i] + cbe_pkg::SUM_W'(1) + cbe_pkg::SUM_W'(r2[i][cbe_pkg::SUM_W-1:W]);
      if (r2[i] >= cbe_pkg::CLAMP_LIMIT) begin
        o_next[i] = cbe_pkg::CH_MAX;
      end else begin
        o_next[i] = t[2*W-1:W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < L; i++) begin
        p1[i] <= p_next[i];
        q1[i] <= q_next[i];
        r2[i] <= r_next[i];
        o3[i] <= o_next[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < L; i++) begin
      m_tdata[i*W +: W] = o3[i];
    end
  end

endmodule

/* hdl/cbe_checker.sv */
// Port-level checks for color_blend_equation, bound to the top level.
// Depends on color_blend_equation port list only.
module cbe_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [31:0]  m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or dropped");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled while output free");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
    else $error("request lost in pipeline");

endmodule

bind color_blend_equation cbe_checker u_cbe_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* verif/color_blend_equation_tb.sv */
// Testbench for color_blend_equation: streams pixel requests under every blend
// equation and checks each blended pixel against an in-bench channel predictor.
// Depends on cbe_pkg and the color_blend_equation RTL.
module color_blend_equation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_REQUESTS = 600;
  localparam int MAX_PRINTED = 20;

  typedef struct packed {
    cbe_pkg::chan_t alpha;
    cbe_pkg::chan_t blue;
    cbe_pkg::chan_t green;
    cbe_pkg::chan_t red;
  } pixel_t;

  class blend_scoreboard;
    cbe_pkg::mode_t mode;
    pixel_t         expected_q[$];
    int             errors;

    function new();
      mode = cbe_pkg::MODE_ADD;
      errors = 0;
    endfunction

    function void set_mode(cbe_pkg::mode_t m);
      mode = m;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // src*sfac combined with dst*dfac, divided by 255 toward zero, clamped
    function cbe_pkg::chan_t blend_lane(cbe_pkg::chan_t src, cbe_pkg::chan_t sfac,
                                        cbe_pkg::chan_t dst, cbe_pkg::chan_t dfac);
      int p;
      int q;
      int v;
      p = int'(src) * int'(sfac);
      q = int'(dst) * int'(dfac);
      case (mode)
        cbe_pkg::MODE_ADD:  v = p + q;
        cbe_pkg::MODE_SUB:  v = p - q;
        cbe_pkg::MODE_RSUB: v = q - p;
        cbe_pkg::MODE_MIN:  v = (p < q) ? p : q;
        cbe_pkg::MODE_MAX:  v = (p > q) ? p : q;
        default:            v = 0;
      endcase
      if (v <= 0) return '0;
      v = v / int'(cbe_pkg::CH_MAX);
      if (v > int'(cbe_pkg::CH_MAX)) v = int'(cbe_pkg::CH_MAX);
      return cbe_pkg::chan_t'(v);
    endfunction

    function void note_request(logic [127:0] d);
      logic [31:0]    sc, sf, dc, df;
      cbe_pkg::chan_t lanes[cbe_pkg::LANES];
      pixel_t         px;
      sc = d[31:0];
      sf = d[63:32];
      dc = d[95:64];
      df = d[127:96];
      for (int c = 0; c < cbe_pkg::LANES; c++)
        lanes[c] = blend_lane(sc[c*cbe_pkg::CH_W +: cbe_pkg::CH_W],
                              sf[c*cbe_pkg::CH_W +: cbe_pkg::CH_W],
                              dc[c*cbe_pkg::CH_W +: cbe_pkg::CH_W],
                              df[c*cbe_pkg::CH_W +: cbe_pkg::CH_W]);
      px.red   = lanes[0];
      px.green = lanes[1];
      px.blue  = lanes[2];
      px.alpha = lanes[3];
      expected_q.push_back(px);
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_field(string name, cbe_pkg::chan_t got, cbe_pkg::chan_t want);
      if (got !== want)
        report($sformatf("%s got %0d expected %0d (mode %0d)", name, got, want, mode));
    endtask

    task check_result(logic [31:0] d);
      pixel_t got;
      pixel_t want;
      got = d;
      if (expected_q.size() == 0) begin
        report($sformatf("pixel 0x%08h with no request pending", d));
        return;
      end
      want = expected_q.pop_front();
      check_field("red_out", got.red, want.red);
      check_field("green_out", got.green, want.green);
      check_field("blue_out", got.blue, want.blue);
      check_field("alpha_out", got.alpha, want.alpha);
    endtask
  endclass

  logic         clk;
  logic         rst;
  logic         blend_mode_we;
  logic [2:0]   blend_mode_wdata;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [31:0]  m_tdata;

  blend_scoreboard sb = new();
  bit              steady;
  int              cycle_count;

  color_blend_equation uut (
    .clk              (clk),
    .rst              (rst),
    .blend_mode_we    (blend_mode_we),
    .blend_mode_wdata (blend_mode_wdata),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_request(s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, 5);
  endfunction

  // downstream backpressure
  initial begin
    int gap;
    m_tready <= 1'b0;
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  function automatic logic [127:0] pack_pixel(logic [31:0] sc, logic [31:0] sf,
                                              logic [31:0] dc, logic [31:0] df);
    return {df, dc, sf, sc};
  endfunction

  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    if ($urandom_range(0, 3) == 0) return $urandom;
    for (int c = 0; c < cbe_pkg::LANES; c++) begin
      case ($urandom_range(0, 4))
        0:       w[c*cbe_pkg::CH_W +: cbe_pkg::CH_W] = '0;
        1:       w[c*cbe_pkg::CH_W +: cbe_pkg::CH_W] = cbe_pkg::CH_MAX;
        2:       w[c*cbe_pkg::CH_W +: cbe_pkg::CH_W] = cbe_pkg::chan_t'(1);
        default: w[c*cbe_pkg::CH_W +: cbe_pkg::CH_W] = cbe_pkg::chan_t'($urandom);
      endcase
    end
    return w;
  endfunction

  function automatic logic [127:0] rand_pixel();
    logic [31:0] sc, sf;
    sc = rand_word();
    sf = rand_word();
    // equal products exercise zero differences and min/max ties
    if ($urandom_range(0, 7) == 0) return pack_pixel(sc, sf, sc, sf);
    return pack_pixel(sc, sf, rand_word(), rand_word());
  endfunction

  // leaves s_tvalid high after the accept; caller drops it at end of burst
  task automatic push_pixel(logic [127:0] d);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
  endtask

  // waits on the clock first so the last accepted request is already on the scoreboard
  task automatic write_mode(cbe_pkg::mode_t m);
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    blend_mode_we    <= 1'b1;
    blend_mode_wdata <= m;
    @(posedge clk);
    blend_mode_we <= 1'b0;
    sb.set_mode(m);
  endtask

  initial begin
    cbe_pkg::mode_t m;
    int             sent;
    int             phase;
    int             n;
    rst              <= 1'b1;
    blend_mode_we    <= 1'b0;
    blend_mode_wdata <= '0;
    s_tvalid         <= 1'b0;
    s_tdata          <= '0;
    steady           = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: reset mode is add, then each equation in turn
    push_pixel(pack_pixel('0, '0, '0, '0));
    push_pixel(pack_pixel(32'hFFFF_FFFF, 32'h0101_0101, 32'h0101_0101, 32'hFEFE_FEFE));
    for (int i = int'(cbe_pkg::MODE_ADD); i <= int'(cbe_pkg::MODE_MAX); i++) begin
      if (cbe_pkg::mode_t'(i) != cbe_pkg::MODE_ADD) begin
        s_tvalid <= 1'b0;
        write_mode(cbe_pkg::mode_t'(i));
      end
      push_pixel(pack_pixel('1, '1, '1, '1));
      push_pixel(pack_pixel('1, '1, '0, '0));
      push_pixel(pack_pixel('0, '0, '1, '1));
      push_pixel(pack_pixel(32'h0180_FF10, 32'h017F_02FE, 32'h0081_FE11, 32'hFF7F_01FD));
    end
    s_tvalid <= 1'b0;

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_REQUESTS) begin
      if (phase == 0) m = cbe_pkg::MODE_MAX;
      else if (phase == 1) m = cbe_pkg::MODE_ADD;
      else m = cbe_pkg::mode_t'($urandom_range(int'(cbe_pkg::MODE_ADD),
                                               int'(cbe_pkg::MODE_MAX)));
      write_mode(m);
      steady = (phase % 4 == 3);
      n = $urandom_range(30, 70);
      repeat (n) push_pixel(rand_pixel());
      s_tvalid <= 1'b0;
      sent += n;
      phase++;
    end
    steady = 1'b0;

    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
hdl/cbe_pkg.sv
hdl/color_blend_equation.sv
hdl/cbe_checker.sv
verif/color_blend_equation_tb.sv
